// ===== hw/rtl/kns_pkg.sv =====
// kns_pkg: shared widths, constants, register indexes, state codes and structs
// for the kernel normalize / circular shift block
// no dependencies
`default_nettype none

package kns_pkg;

    localparam int PIX_W     = 8;              // kernel pixel
    localparam int SIDE_W    = 4;              // kernel side register
    localparam int PSF_W     = 11;             // psf side register
    localparam int SUM_W     = 14;             // running pixel sum
    localparam int DEN_W     = PIX_W + SUM_W;  // max * sum
    localparam int POS_W     = 10;             // psf row / column result
    localparam int VAL_W     = 24;             // weight and scale, Q8.16
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 72;             // 68 payload bits padded to bytes

    localparam logic [PSF_W-1:0] MAX_PSF_SIDE = 11'd1024;
    localparam logic [VAL_W-1:0] VAL_SAT      = 24'hFFFFFF;
    localparam logic [PIX_W-1:0] PIX_FULL     = 8'd255;

    localparam logic [SIDE_W-1:0] RST_KERNEL_SIDE = 4'd5;
    localparam logic [PSF_W-1:0]  RST_PSF_SIDE    = 11'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_WIDTH  = 2'd0,
        CFG_KERNEL_HEIGHT = 2'd1,
        CFG_PSF_WIDTH     = 2'd2,
        CFG_PSF_HEIGHT    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SIDE_W-1:0] kernel_width;
        logic [SIDE_W-1:0] kernel_height;
        logic [PSF_W-1:0]  psf_width;
        logic [PSF_W-1:0]  psf_height;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] psf_row;
        logic [POS_W-1:0] psf_col;
        logic [VAL_W-1:0] weight;
        logic [VAL_W-1:0] scale_factor;
        logic             degenerate;
        logic             last;
    } t_result;

    typedef enum logic [7:0] {
        S_LOAD   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_SCALE  = 8'b0000_0100,
        S_SCALEW = 8'b0000_1000,
        S_FETCH  = 8'b0001_0000,
        S_ISSUE  = 8'b0010_0000,
        S_WAIT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/kns_div.sv =====
// kns_div: shared restoring divider, one quotient bit per cycle, result
// saturated to the 24-bit value range
// depends on kns_pkg
`default_nettype none

module kns_div import kns_pkg::*; #(
    parameter int NUM_W = 33
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [VAL_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_nq;     // numerator bits shift out, quotient bits shift in
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   shifted;
    logic             fits;
    logic [DEN_W:0]   diff;

    assign shifted = {r_rem, r_nq[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = (|r_nq[NUM_W-1:VAL_W]) ? VAL_SAT : r_nq[VAL_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/kns_ctrl.sv =====
// kns_ctrl: kernel load, pixel store, sum/max accumulation and the emission
// sequencer that drives the shared divider
// depends on kns_pkg, kns_div
`default_nettype none

module kns_ctrl import kns_pkg::*; #(
    parameter int MAX_KERNEL_SIDE = 8,
    parameter int FRACTION_BITS   = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_pix_valid,
    output logic                  o_pix_ready,
    input  wire logic [PIX_W-1:0] i_pix,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output t_result               o_res
);

    localparam int AREA   = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
    localparam int ADDR_W = (AREA > 1) ? $clog2(AREA) : 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int CNT_W  = $clog2(AREA + 1);
    localparam int DIV_W  = 2 * PIX_W + 1 + FRACTION_BITS;
    localparam logic [SIDE_W-1:0] K_MAX = SIDE_W'(MAX_KERNEL_SIDE);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [PIX_W-1:0]   r_max;
    logic               r_degen;
    logic [CNT_W-1:0]   r_idx;
    logic [SIDE_W-1:0]  r_row;
    logic [SIDE_W-1:0]  r_col;
    logic [DEN_W-1:0]   r_den;
    logic [VAL_W-1:0]   r_scale;
    logic [VAL_W-1:0]   r_weight;
    logic [PIX_W-1:0]   r_rd_data;
    logic [PIX_W-1:0]   mem [DEPTH];

    logic [SIDE_W-1:0]   kw, kh, cx, cy;
    logic [2*SIDE_W-1:0] area;
    logic [CNT_W-1:0]    total;
    logic [CNT_W-1:0]    cnt_inc, idx_inc;
    logic [PSF_W-1:0]    pw, ph, col_pos, row_pos;
    logic                pix_acc, res_acc, is_last;
    logic [2*PIX_W-1:0]  p255;
    logic                div_start, div_done;
    logic [DIV_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [VAL_W-1:0]    div_quot;

    // effective geometry
    assign kw = (i_cfg.kernel_width == '0) ? SIDE_W'(1) :
                (i_cfg.kernel_width > K_MAX) ? K_MAX : i_cfg.kernel_width;
    assign kh = (i_cfg.kernel_height == '0) ? SIDE_W'(1) :
                (i_cfg.kernel_height > K_MAX) ? K_MAX : i_cfg.kernel_height;
    assign area  = {{SIDE_W{1'b0}}, kw} * {{SIDE_W{1'b0}}, kh};
    assign total = area[CNT_W-1:0];
    assign pw = (i_cfg.psf_width < PSF_W'(kw)) ? PSF_W'(kw) :
                (i_cfg.psf_width > MAX_PSF_SIDE) ? MAX_PSF_SIDE : i_cfg.psf_width;
    assign ph = (i_cfg.psf_height < PSF_W'(kh)) ? PSF_W'(kh) :
                (i_cfg.psf_height > MAX_PSF_SIDE) ? MAX_PSF_SIDE : i_cfg.psf_height;
    assign cx = kw >> 1;
    assign cy = kh >> 1;

    // circular placement around the kernel centre
    assign col_pos = (r_col >= cx) ? PSF_W'(r_col - cx) : (pw - PSF_W'(cx - r_col));
    assign row_pos = (r_row >= cy) ? PSF_W'(r_row - cy) : (ph - PSF_W'(cy - r_row));

    assign cnt_inc = r_count + CNT_W'(1);
    assign idx_inc = r_idx + CNT_W'(1);
    assign is_last = (idx_inc == total);

    assign o_pix_ready = (r_state == S_LOAD);
    assign pix_acc     = o_pix_ready && i_pix_valid;
    assign o_res_valid = (r_state == S_OUT);
    assign res_acc     = o_res_valid && i_res_ready;

    assign o_res.psf_row      = row_pos[POS_W-1:0];
    assign o_res.psf_col      = col_pos[POS_W-1:0];
    assign o_res.weight       = r_weight;
    assign o_res.scale_factor = r_scale;
    assign o_res.degenerate   = r_degen;
    assign o_res.last         = is_last;

    // pixel * 255 without a multiplier
    assign p255 = {r_rd_data, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, r_rd_data};

    always_comb begin
        div_start = 1'b0;
        div_num   = {1'b0, p255, {FRACTION_BITS{1'b0}}};
        div_den   = r_den;
        case (r_state)
            S_SCALE: begin
                div_start = !r_degen;
                div_num   = {{(PIX_W + 1){1'b0}}, PIX_FULL, {FRACTION_BITS{1'b0}}};
                div_den   = {{SUM_W{1'b0}}, r_max};
            end
            S_ISSUE: begin
                div_start = !r_degen;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:   if (pix_acc && cnt_inc >= total) n_state = S_PREP;
            S_PREP:   n_state = S_SCALE;
            S_SCALE:  n_state = r_degen ? S_FETCH : S_SCALEW;
            S_SCALEW: if (div_done) n_state = S_FETCH;
            S_FETCH:  n_state = S_ISSUE;
            S_ISSUE:  n_state = r_degen ? S_OUT : S_WAIT;
            S_WAIT:   if (div_done) n_state = S_OUT;
            S_OUT:    if (res_acc) n_state = is_last ? S_LOAD : S_FETCH;
            default:  n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_sum   <= '0;
            r_max   <= '0;
            r_degen <= 1'b0;
            r_idx   <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            if (pix_acc) begin
                r_count <= cnt_inc;
                r_sum   <= r_sum + SUM_W'(i_pix);
                if (i_pix > r_max) r_max <= i_pix;
            end
            if (r_state == S_PREP) begin
                r_degen <= (r_max == '0) || (r_sum == '0);
            end
            if (res_acc) begin
                if (is_last) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_max   <= '0;
                    r_idx   <= '0;
                    r_row   <= '0;
                    r_col   <= '0;
                end else begin
                    r_idx <= idx_inc;
                    if (r_col + SIDE_W'(1) == kw) begin
                        r_col <= '0;
                        r_row <= r_row + SIDE_W'(1);
                    end else begin
                        r_col <= r_col + SIDE_W'(1);
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) r_den <= DEN_W'(r_max) * DEN_W'(r_sum);
        if (r_state == S_SCALE && r_degen) r_scale <= VAL_SAT;
        if (r_state == S_SCALEW && div_done) r_scale <= div_quot;
        if (r_state == S_ISSUE && r_degen) r_weight <= '0;
        if (r_state == S_WAIT && div_done) r_weight <= div_quot;
    end

    // kernel store, registered read
    always_ff @(posedge i_clk) begin
        if (pix_acc) mem[r_count[ADDR_W-1:0]] <= i_pix;
        r_rd_data <= mem[r_idx[ADDR_W-1:0]];
    end

    kns_div #(
        .NUM_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/kernel_normalize_circshift_top.sv =====
// kernel_normalize_circshift_top: configuration registers, output register and
// the load / emission controller
// depends on kns_pkg, kns_ctrl
`default_nettype none

// Loads a blur kernel one gray pixel per request in raster order, then emits one
// result per kernel element in raster order: the weight pixel*255/(max*sum) in
// unsigned Q8.16 (truncated, saturated), the scale 255/max, the element's PSF
// row and column after the circular shift that puts the kernel centre at (0,0),
// a degenerate flag for an all-zero kernel (weights 0, scale all ones) and tlast
// on the final element. Pixels are taken one per cycle. After the last pixel the
// block is not ready until every result has been handed to the output register:
// one shared restoring divider produces one quotient bit a cycle over
// FRACTION_BITS+17 steps, first for the scale once, then for each weight after
// a fetch from the store, and each result is handed off before the next fetch;
// a degenerate kernel skips the divider. The output register lets the next
// kernel load start while the final result still waits on the master side.
// Configuration writes are taken at any time but belong only between kernels;
// the port is always ready.

module kernel_normalize_circshift_top import kns_pkg::*; #(
    parameter int MAX_KERNEL_SIDE = 8,
    parameter int FRACTION_BITS   = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [PSF_W-1:0]     i_cfg_data,
    // kernel pixel stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [PIX_W-1:0]     i_s_axis_tdata,  // [7:0] kernel_pixel
    // result stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // [9:0] psf_row, [19:10] psf_col, [43:20] weight, [67:44] scale_factor,
    // [71:68] zero
    output logic [TDATA_W-1:0]        o_m_axis_tdata,
    output logic [0:0]                o_m_axis_tuser,  // [0] degenerate
    output logic                      o_m_axis_tlast
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic    res_valid;
    logic    res_ready;
    t_result res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_width  <= RST_KERNEL_SIDE;
            r_cfg.kernel_height <= RST_KERNEL_SIDE;
            r_cfg.psf_width     <= RST_PSF_SIDE;
            r_cfg.psf_height    <= RST_PSF_SIDE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KERNEL_WIDTH:  r_cfg.kernel_width  <= i_cfg_data[SIDE_W-1:0];
                CFG_KERNEL_HEIGHT: r_cfg.kernel_height <= i_cfg_data[SIDE_W-1:0];
                CFG_PSF_WIDTH:     r_cfg.psf_width     <= i_cfg_data;
                CFG_PSF_HEIGHT:    r_cfg.psf_height    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // load, store and emission sequencing with the shared divider
    kns_ctrl #(
        .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_valid (i_s_axis_tvalid),
        .o_pix_ready (o_s_axis_tready),
        .i_pix       (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register: filled when empty or being drained this cycle
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) r_out <= res;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out.scale_factor, r_out.weight,
                              r_out.psf_col, r_out.psf_row};
    assign o_m_axis_tuser  = r_out.degenerate;
    assign o_m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

// ===== hw/rtl/kns_checker.sv =====
// kns_checker: port-level checks on the result stream and ready behavior,
// bound to kernel_normalize_circshift_top
// depends on kns_pkg
`default_nettype none

module kns_checker import kns_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_cfg_ready,
    input wire logic                 o_s_axis_tready,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [TDATA_W-1:0]   o_m_axis_tdata,
    input wire logic [0:0]           o_m_axis_tuser,
    input wire logic                 o_m_axis_tlast
);

    // configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // all-zero kernel forces zero weight and saturated scale
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[43:20] == '0 && o_m_axis_tdata[67:44] == VAL_SAT)
        else $error("degenerate result with nonzero weight or unsaturated scale");

    // a weight never exceeds the scale, since pixel <= max <= sum
    a_weight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata[43:20] <= o_m_axis_tdata[67:44])
        else $error("weight above scale");

    // no pixel is taken while a kernel is still being emitted
    a_no_load_mid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input ready during emission");

endmodule

bind kernel_normalize_circshift_top kns_checker u_kns_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_cfg_ready     (o_cfg_ready),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for kernel_normalize_circshift_top
// predicts normalized Q8.16 weights, scale and circularly shifted psf places per kernel
// depends on kns_pkg and the kernel_normalize_circshift_top rtl
module tb_top;
    import kns_pkg::*;

    localparam int FRAC_BITS     = 16;    // matches the block's default
    localparam int MAX_SIDE      = 8;
    localparam int STORE_SIZE    = 64;
    localparam int SETTLE_CYCLES = 60;    // covers one result of divider work
    localparam int QUIET_LIMIT   = 2000;  // cycles with no request moving at all
    localparam int RANDOM_PIXELS = 50;
    localparam int REPORT_LIMIT  = 10;

    // how the pixels of one random kernel are drawn
    typedef enum int {PIX_ZERO, PIX_TINY, PIX_ANY} t_pix_style;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    // driven inputs, all known from time zero
    logic                 cfg_valid = 1'b0;
    t_cfg_idx             cfg_index = CFG_KERNEL_WIDTH;
    logic [PSF_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic [PIX_W-1:0]     s_data    = '0;
    logic                 m_ready   = 1'b0;

    // observed outputs
    logic                 cfg_ready;
    logic                 s_ready;
    logic                 m_valid;
    logic [TDATA_W-1:0]   m_data;
    logic [0:0]           m_user;
    logic                 m_last;

    // random idling on both sides, switched off for the final stretch
    bit                   idle_en = 1'b1;
    int unsigned          stall_left = 0;

    // predictor copy of the block: geometry registers and load accumulators
    logic [SIDE_W-1:0]    g_kw = RST_KERNEL_SIDE;
    logic [SIDE_W-1:0]    g_kh = RST_KERNEL_SIDE;
    logic [PSF_W-1:0]     g_pw = RST_PSF_SIDE;
    logic [PSF_W-1:0]     g_ph = RST_PSF_SIDE;
    logic [PIX_W-1:0]     kern_img [STORE_SIZE];
    logic [SUM_W-1:0]     tap_sum   = '0;
    logic [PIX_W-1:0]     tap_peak  = '0;
    logic [6:0]           taps_held = '0;

    // weights still owed by the block, oldest first
    t_result              taps_due[$];
    t_result              seen;
    t_result              want;

    int unsigned          mismatches   = 0;
    int unsigned          quiet_cycles = 0;

    kernel_normalize_circshift_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned clamp_side(int unsigned v, int unsigned lo,
                                               int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // circular place of kernel index k when centre ctr is moved to index 0
    function automatic int unsigned wrap_place(int unsigned k, int unsigned ctr,
                                               int unsigned side);
        if (k >= ctr) return k - ctr;
        return side - (ctr - k);
    endfunction

    function automatic logic [VAL_W-1:0] sat24(logic [63:0] v);
        if (v > 64'(VAL_SAT)) return VAL_SAT;
        return v[VAL_W-1:0];
    endfunction

    // one accepted pixel; the pixel that completes the kernel queues every weight
    function automatic void load_kernel_pixel(logic [PIX_W-1:0] pix);
        int unsigned kw, kh, pw, ph, total, r, c, n;
        logic [63:0] den, wt, scl;
        bit          degen;
        t_result     tap;
        kw    = clamp_side(g_kw, 1, MAX_SIDE);
        kh    = clamp_side(g_kh, 1, MAX_SIDE);
        total = kw * kh;
        kern_img[taps_held[5:0]] = pix;
        tap_sum   = tap_sum + SUM_W'(pix);
        if (pix > tap_peak) tap_peak = pix;
        taps_held = taps_held + 7'd1;
        // count checked against the geometry in force now, even if it changed mid-load
        if (taps_held < total) return;
        pw    = clamp_side(g_pw, kw, MAX_PSF_SIDE);
        ph    = clamp_side(g_ph, kh, MAX_PSF_SIDE);
        degen = (tap_peak == 0) || (tap_sum == 0);
        den   = 64'(tap_peak) * 64'(tap_sum);
        // all-zero kernel: scale saturates, weights forced to zero
        scl   = degen ? 64'(VAL_SAT) : (64'(PIX_FULL) << FRAC_BITS) / 64'(tap_peak);
        n = 0;
        for (r = 0; r < kh; r++) begin
            for (c = 0; c < kw; c++) begin
                wt = 64'(kern_img[(r * kw + c) % STORE_SIZE]) * 64'(PIX_FULL);
                wt = degen ? 64'd0 : (wt << FRAC_BITS) / den;
                tap.psf_row      = POS_W'(wrap_place(r, kh / 2, ph));
                tap.psf_col      = POS_W'(wrap_place(c, kw / 2, pw));
                tap.weight       = sat24(wt);
                tap.scale_factor = sat24(scl);
                tap.degenerate   = degen;
                n++;
                tap.last         = (n == total);
                taps_due.push_back(tap);
            end
        end
        tap_sum   = '0;
        tap_peak  = '0;
        taps_held = '0;
    endfunction

    // ----------------------------------------------------------------- drivers

    // one pixel request; valid stays high afterwards unless a gap or a pause follows
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= pix;
        do @(posedge clk); while (!s_ready);
        load_kernel_pixel(pix);
    endtask

    // stop sending, let every owed weight arrive, then let the divider settle
    task automatic await_idle();
        s_valid <= 1'b0;
        while (taps_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes all four geometry registers back to back while the block is quiet
    task automatic set_geometry(input logic [PSF_W-1:0] kw, input logic [PSF_W-1:0] kh,
                                input logic [PSF_W-1:0] pw, input logic [PSF_W-1:0] ph);
        t_cfg_idx         order[4] = '{CFG_KERNEL_WIDTH, CFG_KERNEL_HEIGHT,
                                       CFG_PSF_WIDTH, CFG_PSF_HEIGHT};
        logic [PSF_W-1:0] vals[4];
        int               i;
        vals = '{kw, kh, pw, ph};
        await_idle();
        for (i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (order[i])
                CFG_KERNEL_WIDTH:  g_kw = vals[i][SIDE_W-1:0];
                CFG_KERNEL_HEIGHT: g_kh = vals[i][SIDE_W-1:0];
                CFG_PSF_WIDTH:     g_pw = vals[i];
                CFG_PSF_HEIGHT:    g_ph = vals[i];
                default: begin
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PSF_W-1:0] random_psf_side();
        case ($urandom_range(0, 4))
            0:       return PSF_W'($urandom_range(0, 2047));  // anything the register holds
            1:       return MAX_PSF_SIDE;
            default: return PSF_W'($urandom_range(8, 40));
        endcase
    endfunction

    // receiver stalls in random bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            m_ready    <= 1'b0;
        end else begin
            m_ready    <= 1'b1;
        end
    end

    // ----------------------------------------------------------------- checker

    task automatic count_error(input string msg);
        if (mismatches < REPORT_LIMIT) $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                               input logic [VAL_W-1:0] got_v);
        if (got_v !== exp_v)
            count_error($sformatf("%s mismatch: expected 0x%0h got 0x%0h",
                                  name, exp_v, got_v));
    endtask

    // tdata: [9:0] row, [19:10] col, [43:20] weight, [67:44] scale; tuser[0] degenerate
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            seen.psf_row      = m_data[9:0];
            seen.psf_col      = m_data[19:10];
            seen.weight       = m_data[43:20];
            seen.scale_factor = m_data[67:44];
            seen.degenerate   = m_user[0];
            seen.last         = m_last;
            if (taps_due.size() == 0) begin
                count_error($sformatf("result with nothing owed: row %0d col %0d",
                                      seen.psf_row, seen.psf_col));
            end else begin
                want = taps_due.pop_front();
                check_field("psf_row",      VAL_W'(want.psf_row),    VAL_W'(seen.psf_row));
                check_field("psf_col",      VAL_W'(want.psf_col),    VAL_W'(seen.psf_col));
                check_field("weight",       want.weight,             seen.weight);
                check_field("scale_factor", want.scale_factor,       seen.scale_factor);
                check_field("degenerate",   VAL_W'(want.degenerate), VAL_W'(seen.degenerate));
                check_field("last",         VAL_W'(want.last),       VAL_W'(seen.last));
            end
        end
    end

    // watchdog: too long with no request moving on any channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------- tests

    // 5x5 kernel on a 256x256 psf straight out of reset; walking ones and zeros
    task automatic test_reset_geometry();
        logic [PIX_W-1:0] pattern[25] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16,
                                          8'd32, 8'd64, 8'd128, 8'd254, 8'd253, 8'd251,
                                          8'd247, 8'd239, 8'd223, 8'd191, 8'd127, 8'd85,
                                          8'd170, 8'd3, 8'd200, 8'd17, 8'd99, 8'd42};
        int i;
        for (i = 0; i < 25; i++) send_pixel(pattern[i]);
    endtask

    // width 15 acts as 8, height 0 as 1; psf width 2047 acts as 1024, height 0 as 1;
    // all pixels zero so the kernel is degenerate
    task automatic test_clamped_zero_kernel();
        int i;
        set_geometry(11'd15, 11'd0, 11'd2047, 11'd0);
        for (i = 0; i < 8; i++) send_pixel('0);
    endtask

    // geometry shrinks after one pixel of a 2x1 kernel: the next pixel emits one
    // weight from the first stored pixel, normalized by the peak and the sum of both
    task automatic test_geometry_change_mid_load();
        set_geometry(11'd2, 11'd1, 11'd8, 11'd8);
        send_pixel(8'd10);
        set_geometry(11'd1, 11'd1, 11'd8, 11'd8);
        send_pixel(8'd200);
    endtask

    // mostly well-formed kernels with random geometry and content, some cut short
    task automatic test_random_kernels();
        int unsigned kw, kh, need, sent, i;
        t_pix_style  style;
        logic [PIX_W-1:0] pix;
        bit          cut_short;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) begin
                // rarely any side the register holds, big kernels are slow
                if ($urandom_range(0, 9) == 0) begin
                    kw = $urandom_range(0, 15);
                    kh = $urandom_range(0, 15);
                end else begin
                    kw = $urandom_range(1, 3);
                    kh = $urandom_range(1, 3);
                end
                set_geometry(PSF_W'(kw), PSF_W'(kh), random_psf_side(), random_psf_side());
            end
            kw   = clamp_side(g_kw, 1, MAX_SIDE);
            kh   = clamp_side(g_kh, 1, MAX_SIDE);
            need = (taps_held < kw * kh) ? kw * kh - taps_held : 1;
            cut_short = (need > 1) && ($urandom_range(0, 7) == 0);
            if (cut_short) need = $urandom_range(1, need - 1);
            case ($urandom_range(0, 5))
                0:       style = PIX_ZERO;
                1, 2:    style = PIX_TINY;
                default: style = PIX_ANY;
            endcase
            for (i = 0; i < need; i++) begin
                case (style)
                    PIX_ZERO: pix = '0;
                    PIX_TINY: pix = PIX_W'($urandom_range(0, 3));
                    default:  pix = PIX_W'($urandom_range(0, 255));
                endcase
                send_pixel(pix);
                sent++;
            end
            // partial load: new geometry takes over the pixels already held
            if (cut_short)
                set_geometry(PSF_W'($urandom_range(1, 4)), PSF_W'($urandom_range(1, 4)),
                             random_psf_side(), random_psf_side());
        end
    endtask

    // closing stretch without idling: kernels back to back at full rate
    task automatic test_back_to_back();
        int i;
        idle_en = 1'b0;
        set_geometry(11'd2, 11'd2, 11'd8, 11'd8);
        for (i = 0; i < 12; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_clamped_zero_kernel();
        test_geometry_change_mid_load();
        test_random_kernels();
        test_back_to_back();
        await_idle();
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
